### design/rtt_pkg.sv
// Package for the region track table: field widths, command and result codes,
// the slot entry layout and the control and status words between controller and datapath.
// Depends on nothing; every design file but rtt_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

  // Field widths of the channel words.
  localparam int CMD_W   = 2;
  localparam int COORD_W = 12;
  localparam int AGE_W   = 8;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 6;

  // Default table depth, reset value of the age limit and saturation value of the age.
  localparam int                 RTT_SLOTS       = 16;
  localparam logic [AGE_W-1:0]   MAX_AGE_RESET   = AGE_W'(15);
  localparam logic [AGE_W-1:0]   AGE_SAT         = '1;

  // Command codes of the input word.
  localparam logic [CMD_W-1:0] CMD_FSTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DETECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FEND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Result kinds of the output word.
  localparam logic [KIND_W-1:0] KIND_UPDATED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HELD     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FSTART   = 3'd5;

  // One slot of the table as stored in the RAM.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [AGE_W-1:0]   age;
  } entry_t;

  // What gets written into the current or chosen slot.
  typedef enum logic [1:0] {
    WR_AGE      = 2'd0,
    WR_BOX_CUR  = 2'd1,
    WR_BOX_FREE = 2'd2,
    WR_CLEAR    = 2'd3
  } wr_sel_t;

  // Which result word the datapath loads into the output register.
  typedef enum logic [2:0] {
    EM_FSTART = 3'd0,
    EM_HIT    = 3'd1,
    EM_INS    = 3'd2,
    EM_PEND   = 3'd3,
    EM_TAIL   = 3'd4
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;
    logic      advance;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      emit;
    emit_sel_t emit_sel;
    logic      load_pend;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] new_cmd;
    logic [CMD_W-1:0] cmd;
    logic             last;
    logic             hit;
    logic             ins_ok;
    logic             expire;
    logic             held;
    logic             pend_v;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### design/rtt_channels.sv
// Valid/ready channel interfaces of the region track table: input, result and configuration.
// Depends on rtt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one command word with its box.
interface rtt_in_if import rtt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] box_x;
  logic [COORD_W-1:0] box_y;
  logic [COORD_W-1:0] box_w;
  logic [COORD_W-1:0] box_h;

  modport source (output valid, command, box_x, box_y, box_w, box_h, input ready);
  modport sink   (input valid, command, box_x, box_y, box_w, box_h, output ready);
endinterface

// Result channel: one result word per transfer.
interface rtt_out_if import rtt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SLOT_W-1:0]  slot;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [COORD_W-1:0] out_w;
  logic [COORD_W-1:0] out_h;
  logic               last;

  modport source (output valid, kind, slot, out_x, out_y, out_w, out_h, last, input ready);
  modport sink   (input valid, kind, slot, out_x, out_y, out_w, out_h, last, output ready);
endinterface

// Configuration channel: writes the age limit.
interface rtt_cfg_if import rtt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AGE_W-1:0] max_age;

  modport source (output valid, max_age, input ready);
  modport sink   (input valid, max_age, output ready);
endinterface

`default_nettype wire

### design/region_track_table_core.sv
// Region track table, top level: joins the controller, the datapath and the channel ports.
// Depends on rtt_pkg, rtt_channels, rtt_ctrl, rtt_dp and rtt_ram.
//
// The block keeps SLOTS tracked rectangles in a small RAM and walks it one slot per clock
// for every command word, except where it must wait for room for a result word. The single
// read and write port of the slot RAM sets this figure. The next word is accepted only after
// the walk ends (a detection that hits a slot finishes at that slot), and a frame_end word
// ends only once its last held rectangle goes out after the walk. Stalls on the result
// channel add cycles only when a result word must be loaded while the previous one is still
// waiting. Slots are cleared by valid bits at reset, so no clearing pass follows reset. The
// age limit is written on the configuration channel, which is always ready.
`timescale 1ns / 1ps
`default_nettype none

module region_track_table_core import rtt_pkg::*; #(
  parameter int SLOTS = RTT_SLOTS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rtt_in_if.sink    in_ch,
  rtt_out_if.source out_ch,
  rtt_cfg_if.sink   cfg_ch
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  // Sequencing of one command word.
  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (dp_stat),
    .cmd      (dp_cmd)
  );

  // Slot table, matching logic and output register.
  rtt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .st          (dp_stat),
    .in_command  (in_ch.command),
    .in_box_x    (in_ch.box_x),
    .in_box_y    (in_ch.box_y),
    .in_box_w    (in_ch.box_w),
    .in_box_h    (in_ch.box_h),
    .cfg_wr      (cfg_ch.valid),
    .cfg_max_age (cfg_ch.max_age),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_kind    (out_ch.kind),
    .out_slot    (out_ch.slot),
    .out_x       (out_ch.out_x),
    .out_y       (out_ch.out_y),
    .out_w       (out_ch.out_w),
    .out_h       (out_ch.out_h),
    .out_last    (out_ch.last)
  );

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

endmodule

`default_nettype wire

### design/rtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/rtt_ctrl.sv
// Controller of the region track table: accepts a command word and steps the datapath
// through one scan of the slot table. Depends on rtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtt_ctrl import rtt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_TAIL = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   step;

  // Input is taken only between scans.
  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    step      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.new_cmd != CMD_UNUSED) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        unique case (st.cmd)
          CMD_FSTART: begin
            // Age each slot; the last slot waits for room for the result word.
            if (!st.last) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WR_AGE;
              cmd.advance = 1'b1;
            end else if (st.out_free) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = WR_AGE;
              cmd.emit     = 1'b1;
              cmd.emit_sel = EM_FSTART;
              state_nxt    = S_IDLE;
            end
          end
          CMD_DETECT: begin
            // First overlapping slot wins; otherwise insert at the end of the scan.
            if (st.hit) begin
              if (st.out_free) begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_BOX_CUR;
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_HIT;
                state_nxt    = S_IDLE;
              end
            end else if (st.last) begin
              if (st.out_free) begin
                cmd.wr_en    = st.ins_ok;
                cmd.wr_sel   = WR_BOX_FREE;
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_INS;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.advance = 1'b1;
            end
          end
          CMD_FEND: begin
            // Expired slots are cleared; held slots go out one word behind the scan.
            if (st.expire) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_CLEAR;
              step       = 1'b1;
            end else if (st.held) begin
              if (!st.pend_v) begin
                cmd.load_pend = 1'b1;
                step          = 1'b1;
              end else if (st.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = EM_PEND;
                cmd.load_pend = 1'b1;
                step          = 1'b1;
              end
            end else begin
              step = 1'b1;
            end
            if (step) begin
              if (st.last) begin
                state_nxt = S_TAIL;
              end else begin
                cmd.advance = 1'b1;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_TAIL: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_TAIL;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/rtt_dp.sv
// Datapath of the region track table: slot RAM with valid bits, scan index, overlap test,
// age limit, pending held slot and the output register. Depends on rtt_pkg and rtt_ram.
`timescale 1ns / 1ps
`default_nettype none

module rtt_dp import rtt_pkg::*; #(
  parameter int SLOTS = RTT_SLOTS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                st,
  input  wire logic [CMD_W-1:0]   in_command,
  input  wire logic [COORD_W-1:0] in_box_x,
  input  wire logic [COORD_W-1:0] in_box_y,
  input  wire logic [COORD_W-1:0] in_box_w,
  input  wire logic [COORD_W-1:0] in_box_h,
  input  wire logic               cfg_wr,
  input  wire logic [AGE_W-1:0]   cfg_max_age,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [KIND_W-1:0]       out_kind,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [COORD_W-1:0]      out_x,
  output logic [COORD_W-1:0]      out_y,
  output logic [COORD_W-1:0]      out_w,
  output logic [COORD_W-1:0]      out_h,
  output logic                    out_last
);

  localparam int             IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0]  LAST_IDX = IW'(SLOTS - 1);
  localparam int             EW       = $bits(entry_t);

  // Scan state and captured command word.
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [COORD_W-1:0] bx_r, bx_nxt, by_r, by_nxt, bw_r, bw_nxt, bh_r, bh_nxt;
  logic [AGE_W-1:0]   max_age_r, max_age_nxt;
  logic [SLOTS-1:0]   vld_r, vld_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [IW-1:0]      pend_idx_r, pend_idx_nxt;
  entry_t             pend_ent_r, pend_ent_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt, ow_r, ow_nxt, oh_r, oh_nxt;
  logic               last_r, last_nxt;

  // Slot evaluation.
  logic [EW-1:0]      ram_rd;
  entry_t             ent;
  entry_t             wr_ent;
  logic [IW-1:0]      wr_addr;
  logic [COORD_W:0]   box_right, box_bottom, slot_right, slot_bottom;
  logic               cur_free, live, hit, expire, held, ins_ok, out_free;
  logic [IW-1:0]      ins_slot;

  // Slot table; a slot never written reads as all zero through its valid bit.
  rtt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (EW'(wr_ent)),
    .rd_addr (idx_nxt),
    .rd_data (ram_rd)
  );

  assign ent = vld_r[idx_r] ? entry_t'(ram_rd) : entry_t'('0);

  // Strict overlap of the box with the current slot, edges kept at 13 bits.
  assign box_right   = {1'b0, bx_r} + {1'b0, bw_r};
  assign box_bottom  = {1'b0, by_r} + {1'b0, bh_r};
  assign slot_right  = {1'b0, ent.left} + {1'b0, ent.width};
  assign slot_bottom = {1'b0, ent.top} + {1'b0, ent.height};

  assign cur_free = (ent.width == '0);
  assign hit      = !cur_free &&
                    ({1'b0, ent.left} < box_right) && (slot_right > {1'b0, bx_r}) &&
                    ({1'b0, ent.top} < box_bottom) && (slot_bottom > {1'b0, by_r});

  // Frame end classification of the current slot.
  assign live   = !cur_free && (ent.age != '0);
  assign expire = live && (ent.age > max_age_r);
  assign held   = live && !expire;

  // Insert target: first free slot seen, or the current one when it is free.
  assign ins_ok   = free_found_r || cur_free;
  assign ins_slot = free_found_r ? free_idx_r : idx_r;

  assign out_free = !out_valid_r || out_ready;

  // Status to the controller.
  always_comb begin
    st          = '0;
    st.new_cmd  = in_command;
    st.cmd      = cmd_r;
    st.last     = (idx_r == LAST_IDX);
    st.hit      = hit;
    st.ins_ok   = ins_ok;
    st.expire   = expire;
    st.held     = held;
    st.pend_v   = pend_v_r;
    st.out_free = out_free;
  end

  // Write data and address for the slot table.
  always_comb begin
    wr_ent  = ent;
    wr_addr = idx_r;
    unique case (cmd.wr_sel)
      WR_AGE: begin
        wr_ent.age = (ent.age == AGE_SAT) ? ent.age : ent.age + AGE_W'(1);
      end
      WR_BOX_CUR: begin
        wr_ent = '{left: bx_r, top: by_r, width: bw_r, height: bh_r, age: '0};
      end
      WR_BOX_FREE: begin
        wr_ent  = '{left: bx_r, top: by_r, width: bw_r, height: bh_r, age: '0};
        wr_addr = ins_slot;
      end
      WR_CLEAR: begin
        wr_ent = '0;
      end
    endcase
  end

  // Scan index, free-slot search, captured word, pending held slot and valid bits.
  always_comb begin
    idx_nxt        = idx_r;
    free_idx_nxt   = free_idx_r;
    free_found_nxt = free_found_r;
    cmd_nxt        = cmd_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    bw_nxt         = bw_r;
    bh_nxt         = bh_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    pend_ent_nxt   = pend_ent_r;
    vld_nxt        = vld_r;
    max_age_nxt    = cfg_wr ? cfg_max_age : max_age_r;
    if (cmd.accept) begin
      idx_nxt        = '0;
      free_found_nxt = 1'b0;
      pend_v_nxt     = 1'b0;
      cmd_nxt        = in_command;
      bx_nxt         = in_box_x;
      by_nxt         = in_box_y;
      bw_nxt         = in_box_w;
      bh_nxt         = in_box_h;
    end
    if (cmd.advance) begin
      idx_nxt = idx_r + IW'(1);
      if (cur_free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx_r;
      end
    end
    if (cmd.load_pend) begin
      pend_v_nxt   = 1'b1;
      pend_idx_nxt = idx_r;
      pend_ent_nxt = ent;
    end
    if (cmd.wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  // Output register: load a result word or drain the current one.
  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    ow_nxt        = ow_r;
    oh_nxt        = oh_r;
    last_nxt      = last_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_FSTART;
      slot_nxt      = '0;
      ox_nxt        = '0;
      oy_nxt        = '0;
      ow_nxt        = '0;
      oh_nxt        = '0;
      last_nxt      = 1'b1;
      unique case (cmd.emit_sel) inside
        EM_FSTART: begin
          kind_nxt = KIND_FSTART;
        end
        EM_HIT: begin
          kind_nxt = KIND_UPDATED;
          slot_nxt = SLOT_W'(idx_r);
        end
        EM_INS: begin
          kind_nxt = ins_ok ? KIND_INSERTED : KIND_DROPPED;
          slot_nxt = ins_ok ? SLOT_W'(ins_slot) : '0;
        end
        EM_PEND, EM_TAIL: begin
          if (pend_v_r) begin
            kind_nxt = KIND_HELD;
            slot_nxt = SLOT_W'(pend_idx_r);
            ox_nxt   = pend_ent_r.left;
            oy_nxt   = pend_ent_r.top;
            ow_nxt   = pend_ent_r.width;
            oh_nxt   = pend_ent_r.height;
          end else begin
            kind_nxt = KIND_NONE;
          end
          last_nxt = (cmd.emit_sel == EM_TAIL);
        end
        default: begin
          kind_nxt = KIND_NONE;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      free_found_r <= 1'b0;
      pend_v_r     <= 1'b0;
      vld_r        <= '0;
      max_age_r    <= MAX_AGE_RESET;
      out_valid_r  <= 1'b0;
      cmd_r        <= CMD_UNUSED;
    end else begin
      idx_r        <= idx_nxt;
      free_found_r <= free_found_nxt;
      pend_v_r     <= pend_v_nxt;
      vld_r        <= vld_nxt;
      max_age_r    <= max_age_nxt;
      out_valid_r  <= out_valid_nxt;
      cmd_r        <= cmd_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    bw_r       <= bw_nxt;
    bh_r       <= bh_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_ent_r <= pend_ent_nxt;
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    ow_r       <= ow_nxt;
    oh_r       <= oh_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_slot  = slot_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_w     = ow_r;
  assign out_h     = oh_r;
  assign out_last  = last_r;

  // A result word is loaded only when the output register has room.
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result word loaded while the output register is full");

  // An insert write only goes to a slot that was found free.
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && (cmd.wr_sel == WR_BOX_FREE)) |-> ins_ok)
    else $error("insert write without a free slot");

  // The scan never steps past the last slot.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (idx_r != LAST_IDX))
    else $error("scan index advanced past the last slot");

  // A held word sent ahead of the scan always has a pending slot behind it.
  a_pend_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.emit_sel == EM_PEND)) |=> (out_kind == KIND_HELD) && !out_last)
    else $error("held word sent without a pending slot");

endmodule

`default_nettype wire
